// ----- rtl/core/wsd_pkg.sv -----
// shared types and constants of the websocket frame deframer
`timescale 1ns / 1ps

package wsd_pkg;

  // frame class codes
  localparam logic [1:0] CLS_FAIL    = 2'd0;
  localparam logic [1:0] CLS_CONT    = 2'd1;
  localparam logic [1:0] CLS_MESSAGE = 2'd2;
  localparam logic [1:0] CLS_CONTROL = 2'd3;

  // one result word travelling from the parser to the output stage
  typedef struct packed {
    logic [7:0] raw_byte;   // received octet, still masked
    logic [7:0] key_byte;   // mask octet to apply
    logic       data_valid;
    logic [3:0] opcode;
    logic       fin;
    logic [1:0] frame_class;
    logic       frame_end;
    logic       error;
  } wsd_item_t;

endpackage

// ----- rtl/core/wsd_front.sv -----
// header parser and classifier: turns received octets into result words
`timescale 1ns / 1ps

module wsd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  output logic               push,
  output wsd_pkg::wsd_item_t push_item,
  input  logic               queue_full
);

  localparam logic       PHASE_HEADER  = 1'b0;
  localparam logic       PHASE_PAYLOAD = 1'b1;
  localparam logic [6:0] LEN_CODE_16   = 7'd126;
  localparam logic [6:0] LEN_CODE_64   = 7'd127;
  localparam logic [3:0] MASK_OFF_7    = 4'd2;
  localparam logic [3:0] MASK_OFF_16   = 4'd4;
  localparam logic [3:0] MASK_OFF_64   = 4'd10;

  // frame class from header byte 0 and the open-fragment flag
  function automatic logic [1:0] classify(input logic [7:0] b0, input logic frag);
    logic [1:0] cls;
    cls = wsd_pkg::CLS_FAIL;
    if (b0 == 8'h88 || b0 == 8'h89 || b0 == 8'h8a) begin
      cls = wsd_pkg::CLS_CONTROL;
    end else if (!frag) begin
      if (b0 == 8'h01 || b0 == 8'h02) cls = wsd_pkg::CLS_CONT;
      else if (b0 == 8'h81 || b0 == 8'h82) cls = wsd_pkg::CLS_MESSAGE;
    end else begin
      if (b0 == 8'h00) cls = wsd_pkg::CLS_CONT;
      else if (b0 == 8'h80) cls = wsd_pkg::CLS_MESSAGE;
    end
    return cls;
  endfunction

  logic        phase, phase_next;
  logic [3:0]  header_count, header_count_next;
  logic [7:0]  first_byte, first_byte_next;
  logic [6:0]  short_length, short_length_next;
  logic [31:0] payload_length, payload_length_next;
  logic [31:0] mask_key, mask_key_next;
  logic [31:0] payload_index, payload_index_next;
  logic        frag_open, frag_open_next;
  logic        error_seen, error_seen_next;

  logic        accept;
  logic [1:0]  cls_now;
  logic [3:0]  mask_off;
  logic [7:0]  key_now;
  logic        last_byte;

  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;
  assign cls_now  = classify(first_byte, frag_open);
  assign last_byte = ((payload_index + 32'd1) == payload_length);

  // where the masking key starts in the header
  always_comb begin
    if (short_length == LEN_CODE_16) mask_off = MASK_OFF_16;
    else if (short_length == LEN_CODE_64) mask_off = MASK_OFF_64;
    else mask_off = MASK_OFF_7;
  end

  // key octet for the current payload position
  always_comb begin
    case (payload_index[1:0])
      2'd0:    key_now = mask_key[31:24];
      2'd1:    key_now = mask_key[23:16];
      2'd2:    key_now = mask_key[15:8];
      default: key_now = mask_key[7:0];
    endcase
  end

  // parse state update and result word
  always_comb begin
    phase_next          = phase;
    header_count_next   = header_count;
    first_byte_next     = first_byte;
    short_length_next   = short_length;
    payload_length_next = payload_length;
    mask_key_next       = mask_key;
    payload_index_next  = payload_index;
    frag_open_next      = frag_open;
    error_seen_next     = error_seen;
    push                   = 1'b0;
    push_item.raw_byte     = 8'd0;
    push_item.key_byte     = 8'd0;
    push_item.data_valid   = 1'b0;
    push_item.opcode       = first_byte[3:0];
    push_item.fin          = first_byte[7];
    push_item.frame_class  = cls_now;
    push_item.frame_end    = 1'b1;
    push_item.error        = 1'b0;
    if (accept && !error_seen) begin
      if (phase == PHASE_PAYLOAD) begin
        push                 = 1'b1;
        push_item.raw_byte   = rx_byte;
        push_item.key_byte   = key_now;
        push_item.data_valid = 1'b1;
        push_item.frame_end  = last_byte;
        payload_index_next   = payload_index + 32'd1;
        if (last_byte) begin
          if (cls_now == wsd_pkg::CLS_CONT) frag_open_next = 1'b1;
          else if (cls_now == wsd_pkg::CLS_MESSAGE) frag_open_next = 1'b0;
          phase_next         = PHASE_HEADER;
          header_count_next  = 4'd0;
          payload_index_next = 32'd0;
        end
      end else if (header_count == 4'd0) begin
        first_byte_next   = rx_byte;
        header_count_next = 4'd1;
      end else if (header_count == 4'd1) begin
        short_length_next   = rx_byte[6:0];
        payload_length_next = (rx_byte[6:0] < LEN_CODE_16) ? {25'd0, rx_byte[6:0]} : 32'd0;
        header_count_next   = 4'd2;
      end else if (header_count < mask_off) begin
        payload_length_next = {payload_length[23:0], rx_byte};
        header_count_next   = header_count + 4'd1;
      end else begin
        mask_key_next = {mask_key[23:0], rx_byte};
        if (header_count < 4'(mask_off + 4'd3)) begin
          header_count_next = header_count + 4'd1;
        end else if (cls_now == wsd_pkg::CLS_FAIL) begin
          push              = 1'b1;
          push_item.error   = 1'b1;
          error_seen_next   = 1'b1;
          phase_next        = PHASE_HEADER;
          header_count_next = 4'd0;
        end else if (payload_length == 32'd0) begin
          push = 1'b1;
          if (cls_now == wsd_pkg::CLS_CONT) frag_open_next = 1'b1;
          else if (cls_now == wsd_pkg::CLS_MESSAGE) frag_open_next = 1'b0;
          phase_next         = PHASE_HEADER;
          header_count_next  = 4'd0;
          payload_index_next = 32'd0;
        end else begin
          phase_next         = PHASE_PAYLOAD;
          payload_index_next = 32'd0;
          header_count_next  = 4'd0;
        end
      end
    end
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PHASE_HEADER;
      header_count   <= 4'd0;
      first_byte     <= 8'd0;
      short_length   <= 7'd0;
      payload_length <= 32'd0;
      mask_key       <= 32'd0;
      payload_index  <= 32'd0;
      frag_open      <= 1'b0;
      error_seen     <= 1'b0;
    end else begin
      phase          <= phase_next;
      header_count   <= header_count_next;
      first_byte     <= first_byte_next;
      short_length   <= short_length_next;
      payload_length <= payload_length_next;
      mask_key       <= mask_key_next;
      payload_index  <= payload_index_next;
      frag_open      <= frag_open_next;
      error_seen     <= error_seen_next;
    end
  end

endmodule

// ----- rtl/core/wsd_queue.sv -----
// short queue of result words between parser and output stage
`timescale 1ns / 1ps

module wsd_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  wsd_pkg::wsd_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output wsd_pkg::wsd_item_t head_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  wsd_pkg::wsd_item_t slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head_item = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_item;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

// ----- rtl/core/wsd_back.sv -----
// output stage: unmasks the payload octet and holds the result word
`timescale 1ns / 1ps

module wsd_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               not_empty,
  input  wsd_pkg::wsd_item_t head_item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         data_byte,
  output logic               data_valid,
  output logic [3:0]         frame_opcode,
  output logic               fin_flag,
  output logic [1:0]         frame_class,
  output logic               frame_end,
  output logic               error_flag
);

  assign pop = not_empty && (!out_valid || !out_stall);

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= not_empty;
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (pop) begin
      data_byte    <= head_item.raw_byte ^ head_item.key_byte;
      data_valid   <= head_item.data_valid;
      frame_opcode <= head_item.opcode;
      fin_flag     <= head_item.fin;
      frame_class  <= head_item.frame_class;
      frame_end    <= head_item.frame_end;
      error_flag   <= head_item.error;
    end
  end

endmodule

// ----- rtl/core/websocket_frame_deframer_unit.sv -----
// top level of the websocket frame deframer
`timescale 1ns / 1ps

// Receive-side websocket deframer. One octet is taken per clock unless in_stall
// is high; header octets (byte 0, length byte, optional 2- or 8-octet extended
// length, 4-octet key) are absorbed, and each payload octet comes out unmasked,
// so the sustained rate is one octet per cycle while out_stall is low. A short
// queue of QUEUE_DEPTH words sits between the parser and the output register;
// in_stall rises only when that queue is full. A result word passes through
// that queue and then the output register. Empty frames give one word with
// data_valid low; a frame of the fail class gives one word with error_flag high,
// after which all input is taken and dropped until reset.
module websocket_frame_deframer_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] data_byte,
  output logic       data_valid,
  output logic [3:0] frame_opcode,
  output logic       fin_flag,
  output logic [1:0] frame_class,
  output logic       frame_end,
  output logic       error_flag
);

  logic               push, full, pop, not_empty;
  wsd_pkg::wsd_item_t push_item, head_item;

  // header parser
  wsd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .push       (push),
    .push_item  (push_item),
    .queue_full (full)
  );

  // result queue
  wsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head_item (head_item)
  );

  // output stage
  wsd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .not_empty    (not_empty),
    .head_item    (head_item),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .data_byte    (data_byte),
    .data_valid   (data_valid),
    .frame_opcode (frame_opcode),
    .fin_flag     (fin_flag),
    .frame_class  (frame_class),
    .frame_end    (frame_end),
    .error_flag   (error_flag)
  );

endmodule
